[design/ppl_pkg.sv]
package ppl_pkg;

  typedef enum logic [3:0] {
    M_IDLE         = 4'd0,
    M_IDENT        = 4'd1,
    M_WIDE         = 4'd2,
    M_NUMBER       = 4'd3,
    M_QUOTE        = 4'd4,
    M_QUOTE_ESC    = 4'd5,
    M_COMMENT      = 4'd6,
    M_COMMENT_STAR = 4'd7,
    M_LINE_COMMENT = 4'd8,
    M_PUNCT        = 4'd9
  } mode_t;

  localparam logic [2:0] KIND_IDENT   = 3'd0;
  localparam logic [2:0] KIND_NUMBER  = 3'd1;
  localparam logic [2:0] KIND_CHAR    = 3'd2;
  localparam logic [2:0] KIND_STRING  = 3'd3;
  localparam logic [2:0] KIND_PUNCT   = 3'd4;
  localparam logic [2:0] KIND_NEWLINE = 3'd5;
  localparam logic [2:0] KIND_EOF     = 3'd6;

  localparam int MAX_RES = 4;

  // per-result kind and flags, one per slot of a queue entry
  typedef struct packed {
    logic [2:0] kind;
    logic       begins_line;
    logic       space_before;
    logic       comment_error;
  } res_tag_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c == 8'h5F) || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C;
  endfunction

  // = ! & | + * / % ^ # - < >
  function automatic logic takes_eq(input logic [7:0] c);
    return c == 8'h3D || c == 8'h21 || c == 8'h26 || c == 8'h7C || c == 8'h2B ||
           c == 8'h2A || c == 8'h2F || c == 8'h25 || c == 8'h5E || c == 8'h23 ||
           c == 8'h2D || c == 8'h3C || c == 8'h3E;
  endfunction

  function automatic logic pairs_with(input logic [7:0] h, input logic [7:0] c);
    return (c == 8'h3D && takes_eq(h)) ||
           (h == 8'h2D && (c == 8'h3E || c == 8'h2D)) ||
           (h == 8'h2B && c == 8'h2B) || (h == 8'h26 && c == 8'h26) ||
           (h == 8'h7C && c == 8'h7C) || (h == 8'h23 && c == 8'h23);
  endfunction

endpackage

[design/ppl_front.sv]
module ppl_front #(
  parameter int P = 32,
  parameter int L = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  acc,
  input  logic [7:0]                            c_in,
  input  logic                                  last_in,
  output logic                                  push,
  output logic [2:0]                            cnt,
  output ppl_pkg::res_tag_t [ppl_pkg::MAX_RES-1:0] tags,
  output logic [ppl_pkg::MAX_RES-1:0][P-1:0]    starts,
  output logic [ppl_pkg::MAX_RES-1:0][L-1:0]    lens
);

  ppl_pkg::mode_t md_r, md_nxt;
  logic [7:0]   h0_r, h0_nxt;
  logic [1:0]   hc_r, hc_nxt;
  logic [P-1:0] pos_r, pos_nxt;
  logic [P-1:0] st_r, st_nxt;
  logic [L-1:0] ln_r, ln_nxt;
  logic [7:0]   q_r, q_nxt;
  logic [7:0]   pv_r, pv_nxt;
  logic         als_r, als_nxt;
  logic         sp_r, sp_nxt;

  always_comb begin
    ppl_pkg::mode_t md;
    logic [7:0]   h0, c;
    logic [1:0]   hc;
    logic [P-1:0] st, pos1, es;
    logic [L-1:0] ln, el;
    logic [7:0]   q, pv;
    logic         als, sp, again, ev, enl, err;
    logic [2:0]   n, ek, lk;
    logic [2:0]   fv;
    logic [2:0][2:0]   fk;
    logic [2:0][P-1:0] fs;
    logic [2:0][L-1:0] fl;

    md = md_r; h0 = h0_r; hc = hc_r; st = st_r; ln = ln_r; q = q_r; pv = pv_r;
    als = als_r; sp = sp_r; c = c_in; n = 3'd0; again = 1'b1; err = 1'b0;
    pos1 = pos_r + P'(1);
    tags = '0; starts = '0; lens = '0;

    for (int r = 0; r < 4; r++) begin
      if (again) begin
        again = 1'b0; ev = 1'b0; enl = 1'b0; ek = ppl_pkg::KIND_PUNCT; es = st; el = L'(1);
        lk = (q == 8'h27) ? ppl_pkg::KIND_CHAR : ppl_pkg::KIND_STRING;
        case (md)
          ppl_pkg::M_IDENT: begin
            if (ppl_pkg::is_word(c)) begin
              if (ln != '1) ln = ln + L'(1);
            end else begin
              ev = 1'b1; ek = ppl_pkg::KIND_IDENT; el = ln;
              md = ppl_pkg::M_IDLE; hc = 2'd0; again = 1'b1;
            end
          end
          ppl_pkg::M_WIDE: begin
            if (c == 8'h27 || c == 8'h22) begin
              if (ln != '1) ln = ln + L'(1);
              q = c; md = ppl_pkg::M_QUOTE;
            end else begin
              md = ppl_pkg::M_IDENT; again = 1'b1;
            end
          end
          ppl_pkg::M_NUMBER: begin
            if (ppl_pkg::is_word(c) || c == 8'h2E ||
                ((c == 8'h2B || c == 8'h2D) &&
                 (pv == 8'h65 || pv == 8'h45 || pv == 8'h70 || pv == 8'h50))) begin
              if (ln != '1) ln = ln + L'(1);
              pv = c;
            end else begin
              ev = 1'b1; ek = ppl_pkg::KIND_NUMBER; el = ln;
              md = ppl_pkg::M_IDLE; hc = 2'd0; again = 1'b1;
            end
          end
          ppl_pkg::M_QUOTE: begin
            if (c == 8'h0A) begin
              ev = 1'b1; ek = lk; el = ln;
              md = ppl_pkg::M_IDLE; hc = 2'd0; again = 1'b1;
            end else begin
              if (ln != '1) ln = ln + L'(1);
              if (c == 8'h5C) begin
                md = ppl_pkg::M_QUOTE_ESC;
              end else if (c == q) begin
                ev = 1'b1; ek = lk; el = ln;
                md = ppl_pkg::M_IDLE; hc = 2'd0;
              end
            end
          end
          ppl_pkg::M_QUOTE_ESC: begin
            if (ln != '1) ln = ln + L'(1);
            md = ppl_pkg::M_QUOTE;
          end
          ppl_pkg::M_COMMENT, ppl_pkg::M_COMMENT_STAR: begin
            if (md == ppl_pkg::M_COMMENT_STAR && c == 8'h2F) begin
              sp = 1'b1; md = ppl_pkg::M_IDLE; hc = 2'd0;
            end else if (c == 8'h2A) begin
              md = ppl_pkg::M_COMMENT_STAR;
            end else begin
              if (c == 8'h0A) begin
                ev = 1'b1; enl = 1'b1; ek = ppl_pkg::KIND_NEWLINE; es = pos_r;
              end
              md = ppl_pkg::M_COMMENT;
            end
          end
          ppl_pkg::M_LINE_COMMENT: begin
            if (c == 8'h0A) begin
              md = ppl_pkg::M_IDLE; hc = 2'd0; again = 1'b1;
            end
          end
          ppl_pkg::M_PUNCT: begin
            if (hc < 2'd2) begin
              if (h0 == 8'h2F && (c == 8'h2A || c == 8'h2F)) begin
                sp = 1'b1; hc = 2'd0;
                md = (c == 8'h2A) ? ppl_pkg::M_COMMENT : ppl_pkg::M_LINE_COMMENT;
              end else if (h0 == 8'h2E && ppl_pkg::is_digit(c)) begin
                ln = L'(2); pv = c; hc = 2'd0; md = ppl_pkg::M_NUMBER;
              end else if ((h0 == 8'h2E || h0 == 8'h3C || h0 == 8'h3E) && c == h0) begin
                hc = 2'd2;
              end else if (ppl_pkg::pairs_with(h0, c)) begin
                ev = 1'b1; el = L'(2); md = ppl_pkg::M_IDLE; hc = 2'd0;
              end else begin
                ev = 1'b1; md = ppl_pkg::M_IDLE; hc = 2'd0; again = 1'b1;
              end
            end else if (c == ((h0 == 8'h2E) ? 8'h2E : 8'h3D)) begin
              ev = 1'b1; el = L'(3); md = ppl_pkg::M_IDLE; hc = 2'd0;
            end else if (h0 == 8'h2E) begin
              // ".." then something else: first dot goes out, second stays held
              ev = 1'b1; st = st + P'(1); hc = 2'd1; again = 1'b1;
            end else begin
              ev = 1'b1; el = L'(2); md = ppl_pkg::M_IDLE; hc = 2'd0; again = 1'b1;
            end
          end
          default: begin
            md = ppl_pkg::M_IDLE; hc = 2'd0; st = pos_r; ln = L'(1); es = pos_r;
            if (ppl_pkg::is_space(c)) begin
              sp = 1'b1;
            end else if (c == 8'h0A) begin
              ev = 1'b1; enl = 1'b1; ek = ppl_pkg::KIND_NEWLINE;
            end else if (ppl_pkg::is_alpha(c)) begin
              md = (c == 8'h4C) ? ppl_pkg::M_WIDE : ppl_pkg::M_IDENT;
            end else if (ppl_pkg::is_digit(c)) begin
              pv = 8'h00; md = ppl_pkg::M_NUMBER;
            end else if (c == 8'h27 || c == 8'h22) begin
              q = c; md = ppl_pkg::M_QUOTE;
            end else if (c == 8'h2E || ppl_pkg::takes_eq(c)) begin
              h0 = c; hc = 2'd1; md = ppl_pkg::M_PUNCT;
            end else begin
              ev = 1'b1;
            end
          end
        endcase
        if (ev) begin
          if (n < 3'd4) begin
            tags[n[1:0]]   = '{kind: ek, begins_line: als, space_before: sp, comment_error: 1'b0};
            starts[n[1:0]] = es;
            lens[n[1:0]]   = el;
            n = n + 3'd1;
          end
          als = enl; sp = 1'b0;
        end
      end
    end

    // end of input: flush held token, then end-of-file marker
    fv = 3'b100; fk = '0; fs = '0; fl = '0;
    fk[2] = ppl_pkg::KIND_EOF; fs[2] = pos1; fl[2] = '0;
    lk = (q == 8'h27) ? ppl_pkg::KIND_CHAR : ppl_pkg::KIND_STRING;
    case (md)
      ppl_pkg::M_IDENT, ppl_pkg::M_WIDE: begin
        fv[0] = 1'b1; fk[0] = ppl_pkg::KIND_IDENT; fs[0] = st; fl[0] = ln;
      end
      ppl_pkg::M_NUMBER: begin
        fv[0] = 1'b1; fk[0] = ppl_pkg::KIND_NUMBER; fs[0] = st; fl[0] = ln;
      end
      ppl_pkg::M_QUOTE, ppl_pkg::M_QUOTE_ESC: begin
        fv[0] = 1'b1; fk[0] = lk; fs[0] = st; fl[0] = ln;
      end
      ppl_pkg::M_COMMENT, ppl_pkg::M_COMMENT_STAR: err = 1'b1;
      ppl_pkg::M_PUNCT: begin
        fv[0] = 1'b1; fk[0] = ppl_pkg::KIND_PUNCT; fs[0] = st; fl[0] = L'(1);
        if (hc >= 2'd2 && h0 == 8'h2E) begin
          fv[1] = 1'b1; fk[1] = ppl_pkg::KIND_PUNCT; fs[1] = st + P'(1); fl[1] = L'(1);
        end else if (hc >= 2'd2) begin
          fl[0] = L'(2);
        end
      end
      default: ;
    endcase

    if (last_in) begin
      for (int k = 0; k < 3; k++) begin
        if (fv[k]) begin
          if (n < 3'd4) begin
            tags[n[1:0]] = '{kind: fk[k], begins_line: als, space_before: sp,
                             comment_error: (k == 2) ? err : 1'b0};
            starts[n[1:0]] = fs[k];
            lens[n[1:0]]   = fl[k];
            n = n + 3'd1;
          end
          als = 1'b0; sp = 1'b0;
        end
      end
    end

    cnt  = n;
    push = acc && (n != 3'd0);

    if (last_in) begin
      md_nxt = ppl_pkg::M_IDLE; h0_nxt = '0; hc_nxt = '0; pos_nxt = '0; st_nxt = '0;
      ln_nxt = '0; q_nxt = '0; pv_nxt = '0; als_nxt = 1'b1; sp_nxt = 1'b0;
    end else begin
      md_nxt = md; h0_nxt = h0; hc_nxt = hc; pos_nxt = pos1; st_nxt = st;
      ln_nxt = ln; q_nxt = q; pv_nxt = pv; als_nxt = als; sp_nxt = sp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      md_r <= ppl_pkg::M_IDLE; h0_r <= '0; hc_r <= '0; pos_r <= '0; st_r <= '0;
      ln_r <= '0; q_r <= '0; pv_r <= '0; als_r <= 1'b1; sp_r <= 1'b0;
    end else if (acc) begin
      md_r <= md_nxt; h0_r <= h0_nxt; hc_r <= hc_nxt; pos_r <= pos_nxt; st_r <= st_nxt;
      ln_r <= ln_nxt; q_r <= q_nxt; pv_r <= pv_nxt; als_r <= als_nxt; sp_r <= sp_nxt;
    end
  end

endmodule

[design/ppl_queue.sv]
module ppl_queue #(
  parameter int P = 32,
  parameter int L = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push,
  input  logic [2:0]                            w_cnt,
  input  ppl_pkg::res_tag_t [ppl_pkg::MAX_RES-1:0] w_tags,
  input  logic [ppl_pkg::MAX_RES-1:0][P-1:0]    w_starts,
  input  logic [ppl_pkg::MAX_RES-1:0][L-1:0]    w_lens,
  input  logic                                  pop,
  output logic                                  full,
  output logic                                  not_empty,
  output logic [2:0]                            r_cnt,
  output ppl_pkg::res_tag_t [ppl_pkg::MAX_RES-1:0] r_tags,
  output logic [ppl_pkg::MAX_RES-1:0][P-1:0]    r_starts,
  output logic [ppl_pkg::MAX_RES-1:0][L-1:0]    r_lens
);

  logic [2:0]                               cnt_q   [2];
  ppl_pkg::res_tag_t [ppl_pkg::MAX_RES-1:0] tags_q  [2];
  logic [ppl_pkg::MAX_RES-1:0][P-1:0]       starts_q[2];
  logic [ppl_pkg::MAX_RES-1:0][L-1:0]       lens_q  [2];
  logic       wp_r, rp_r;
  logic [1:0] fill_r;

  assign full      = (fill_r == 2'd2);
  assign not_empty = (fill_r != 2'd0);
  assign r_cnt     = cnt_q[rp_r];
  assign r_tags    = tags_q[rp_r];
  assign r_starts  = starts_q[rp_r];
  assign r_lens    = lens_q[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      cnt_q[wp_r]    <= w_cnt;
      tags_q[wp_r]   <= w_tags;
      starts_q[wp_r] <= w_starts;
      lens_q[wp_r]   <= w_lens;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; fill_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[design/ppl_back.sv]
module ppl_back #(
  parameter int P = 32,
  parameter int L = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_valid,
  input  logic [2:0]                            q_cnt,
  input  ppl_pkg::res_tag_t [ppl_pkg::MAX_RES-1:0] q_tags,
  input  logic [ppl_pkg::MAX_RES-1:0][P-1:0]    q_starts,
  input  logic [ppl_pkg::MAX_RES-1:0][L-1:0]    q_lens,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output ppl_pkg::res_tag_t                     o_tag,
  output logic [P-1:0]                          o_start,
  output logic [L-1:0]                          o_len,
  output logic                                  o_last
);

  logic       ov_r, ov_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       load, is_last;

  ppl_pkg::res_tag_t tag_r;
  logic [P-1:0]      start_r;
  logic [L-1:0]      len_r;
  logic              last_r;

  assign load    = q_valid && (!ov_r || !out_stall);
  assign is_last = ({1'b0, idx_r} + 3'd1) == q_cnt;
  assign pop     = load && is_last;

  always_comb begin
    ov_nxt  = ov_r;
    idx_nxt = idx_r;
    if (load) begin
      ov_nxt  = 1'b1;
      idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      ov_r  <= ov_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tag_r   <= q_tags[idx_r];
      start_r <= q_starts[idx_r];
      len_r   <= q_lens[idx_r];
      last_r  <= is_last;
    end
  end

  assign out_valid = ov_r;
  assign o_tag     = tag_r;
  assign o_start   = start_r;
  assign o_len     = len_r;
  assign o_last    = last_r;

endmodule

[design/preprocessing_token_lexer_top.sv]
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall   | in_char_in[7:0], in_is_last
// out     | output    | out_valid/out_stall | kind, start, length, flags, last_result
//
// One character is taken per cycle while in_stall is low. A character
// yields up to 4 token results, handed out one result per transfer;
// a two-entry queue between the lexer front and the result sequencer
// absorbs those bursts, and in_stall rises only while that queue is full.
// Synchronous active-low reset; after the last character of a stream the
// lexer returns to its reset state on its own.
module preprocessing_token_lexer_top #(
  parameter int POSITION_BITS = 32,
  parameter int LENGTH_BITS   = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_char_in,
  input  logic                     in_is_last,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               out_token_kind,
  output logic [POSITION_BITS-1:0] out_token_start,
  output logic [LENGTH_BITS-1:0]   out_token_length,
  output logic                     out_begins_line,
  output logic                     out_space_before,
  output logic                     out_comment_error,
  output logic                     out_last_result
);

  logic acc, push, pop, full, q_ne;
  logic [2:0] f_cnt, q_cnt;
  ppl_pkg::res_tag_t [ppl_pkg::MAX_RES-1:0]     f_tags, q_tags;
  logic [ppl_pkg::MAX_RES-1:0][POSITION_BITS-1:0] f_starts, q_starts;
  logic [ppl_pkg::MAX_RES-1:0][LENGTH_BITS-1:0]   f_lens, q_lens;
  ppl_pkg::res_tag_t o_tag;

  // stall comes from the registered queue fill only
  assign in_stall = full;
  assign acc      = in_valid && !full;

  ppl_front #(.P(POSITION_BITS), .L(LENGTH_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc), .c_in(in_char_in), .last_in(in_is_last),
    .push(push), .cnt(f_cnt), .tags(f_tags), .starts(f_starts), .lens(f_lens)
  );

  ppl_queue #(.P(POSITION_BITS), .L(LENGTH_BITS)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .w_cnt(f_cnt), .w_tags(f_tags),
    .w_starts(f_starts), .w_lens(f_lens), .pop(pop), .full(full), .not_empty(q_ne),
    .r_cnt(q_cnt), .r_tags(q_tags), .r_starts(q_starts), .r_lens(q_lens)
  );

  ppl_back #(.P(POSITION_BITS), .L(LENGTH_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_ne), .q_cnt(q_cnt), .q_tags(q_tags),
    .q_starts(q_starts), .q_lens(q_lens), .pop(pop), .out_valid(out_valid),
    .out_stall(out_stall), .o_tag(o_tag), .o_start(out_token_start),
    .o_len(out_token_length), .o_last(out_last_result)
  );

  assign out_token_kind    = o_tag.kind;
  assign out_begins_line   = o_tag.begins_line;
  assign out_space_before  = o_tag.space_before;
  assign out_comment_error = o_tag.comment_error;

endmodule
